>>> rtl/tfrp_pkg.sv
package tfrp_pkg;

  localparam int unsigned LimitWidth = 4;
  localparam logic [LimitWidth-1:0] LimitReset = 4'd8;

  typedef enum logic [1:0] {
    PH_MARKER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_STOPPED = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    KIND_ENC   = 3'd0,
    KIND_DUTY  = 3'd1,
    KIND_BANK0 = 3'd2,
    KIND_BANK1 = 3'd3,
    KIND_BANK2 = 3'd4,
    KIND_BANK3 = 3'd5,
    KIND_BANK6 = 3'd6,
    KIND_BAD   = 3'd7
  } kind_t;

  localparam logic [7:0] MarkerEnc   = 8'h01;
  localparam logic [7:0] MarkerDuty  = 8'h02;
  localparam logic [7:0] MarkerBank0 = 8'h10;
  localparam logic [7:0] MarkerBank1 = 8'h11;
  localparam logic [7:0] MarkerBank2 = 8'h12;
  localparam logic [7:0] MarkerBank3 = 8'h13;
  localparam logic [7:0] MarkerBank6 = 8'h16;
  // stop marker, listed for completeness: it decodes as bad like any unknown one
  localparam logic [7:0] MarkerStop  = 8'hF0;

  // duty scale: 100 percent in q16 is raw * 100 / 65536
  localparam logic [6:0] DutyScale = 7'd100;

  typedef struct packed {
    logic               valid;
    logic [2:0]         record_kind;
    logic [1:0]         lane;
    logic signed [31:0] value;
    logic [22:0]        duty_scaled;
  } result_t;

  function automatic kind_t kind_of_marker(input logic [7:0] m);
    kind_t k;
    k = KIND_BAD;
    case (m)
      MarkerEnc:   k = KIND_ENC;
      MarkerDuty:  k = KIND_DUTY;
      MarkerBank0: k = KIND_BANK0;
      MarkerBank1: k = KIND_BANK1;
      MarkerBank2: k = KIND_BANK2;
      MarkerBank3: k = KIND_BANK3;
      MarkerBank6: k = KIND_BANK6;
      MarkerStop:  k = KIND_BAD;
      default:     k = KIND_BAD;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/tfrp_if.sv
interface tfrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface tfrp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         record_kind;
  logic [1:0]         lane;
  logic signed [31:0] value;
  logic [22:0]        duty_scaled;

  modport source (output valid, output record_kind, output lane, output value,
                  output duty_scaled, input ready);
  modport sink (input valid, input record_kind, input lane, input value,
                input duty_scaled, output ready);
endinterface

>>> rtl/tfrp_core.sv
module tfrp_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic [7:0]                          data_byte,
  input  logic                                frame_start,
  input  logic [tfrp_pkg::LimitWidth-1:0]     message_limit,
  output tfrp_pkg::result_t                   result
);
  import tfrp_pkg::*;

  phase_t                phase, phase_next, phase_eff;
  kind_t                 kind, kind_next, kind_dec;
  logic [2:0]            pos, pos_next, pos_eff;
  logic [LimitWidth-1:0] count, count_next, count_eff;
  logic [23:0]           word, word_next, word_eff;
  logic [15:0]           half;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_MARKER;
      kind  <= KIND_ENC;
      pos   <= '0;
      count <= '0;
      word  <= '0;
    end else if (accept) begin
      phase <= phase_next;
      kind  <= kind_next;
      pos   <= pos_next;
      count <= count_next;
      word  <= word_next;
    end
  end

  always_comb begin
    // frame start clears the parse before the byte is looked at
    phase_eff = frame_start ? PH_MARKER : phase;
    count_eff = frame_start ? '0 : count;
    pos_eff   = frame_start ? '0 : pos;
    word_eff  = frame_start ? '0 : word;
    kind_dec  = kind_of_marker(data_byte);

    phase_next = phase_eff;
    kind_next  = kind;
    pos_next   = pos_eff;
    count_next = count_eff;
    word_next  = word_eff;
    half       = {data_byte, (pos_eff[1] ? word_eff[23:16] : word_eff[7:0])};

    result             = '0;
    result.record_kind = kind;

    case (phase_eff)
      PH_MARKER: begin
        if (count_eff >= message_limit) begin
          phase_next = PH_STOPPED;
        end else begin
          count_next = count_eff + LimitWidth'(1);
          if (kind_dec == KIND_BAD) begin
            phase_next = PH_STOPPED;
          end else begin
            kind_next  = kind_dec;
            pos_next   = '0;
            word_next  = '0;
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        pos_next = pos_eff + 3'd1;
        case (pos_eff[1:0])
          2'd0:    word_next[7:0]   = data_byte;
          2'd1:    word_next[15:8]  = data_byte;
          2'd2:    word_next[23:16] = data_byte;
          default: word_next        = word_eff;
        endcase
        case (kind)
          KIND_ENC: begin
            if (pos_eff == 3'd3) begin
              result.valid = 1'b1;
              result.value = {data_byte, word_eff};
              phase_next   = PH_MARKER;
            end
          end
          KIND_DUTY: begin
            if (pos_eff == 3'd1) begin
              result.valid       = 1'b1;
              result.value       = {16'd0, half};
              result.duty_scaled = 23'(half) * 23'(DutyScale);
              phase_next         = PH_MARKER;
            end
          end
          default: begin
            // analog bank: a lane completes on every odd payload byte
            if (pos_eff[0]) begin
              result.valid = 1'b1;
              result.lane  = pos_eff[2:1];
              result.value = {16'd0, half};
              if (pos_eff == 3'd7) begin
                phase_next = PH_MARKER;
              end
            end
          end
        endcase
      end
      default: begin
        phase_next = phase_eff;
      end
    endcase
  end

endmodule

>>> rtl/tagged_frame_record_parser.sv
// Byte-wide tagged record parser. One frame byte is taken per cycle on in_ch,
// with frame_start high on the first byte of each frame; a byte may be taken
// in every cycle while out_ch keeps up, but while a finished record waits on
// out_ch with ready low, in_ch.ready is held low until that record is taken.
// Each byte is decoded in the cycle it is taken and its record, if any, is
// presented on out_ch in the next cycle; throughput is one byte per cycle
// while out_ch is ready. Marker 0x01 gives one encoder item after its four
// payload bytes, marker 0x02 one duty item after two bytes (with the duty
// also scaled to a q16 percentage), and markers 0x10-0x13 and 0x16 give one
// analog item per two-byte lane, four lanes per record. Marker 0xF0, an
// unknown marker, or a marker beyond message_limit records stops parsing
// until the next frame start; a record already begun runs to its end.
// message_limit is written through cfg_wr_en/cfg_wr_data; the user must write
// it only while the block is idle, which the block itself does not enforce.
module tagged_frame_record_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [tfrp_pkg::LimitWidth-1:0] cfg_wr_data,
  tfrp_in_if.sink                         in_ch,
  tfrp_out_if.source                      out_ch
);
  import tfrp_pkg::*;

  logic [LimitWidth-1:0] message_limit;
  logic                  in_accept;
  result_t               result;
  logic                  out_valid;

  // message limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      message_limit <= LimitReset;
    end else if (cfg_wr_en) begin
      message_limit <= cfg_wr_data;
    end
  end

  // take a byte whenever the output register is empty or being drained
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  // parse state and per-byte decode
  tfrp_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_accept),
    .data_byte     (in_ch.data_byte),
    .frame_start   (in_ch.frame_start),
    .message_limit (message_limit),
    .result        (result)
  );

  // output register: valid is control, payload loads only with a new item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && result.valid) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && result.valid) begin
      out_ch.record_kind <= result.record_kind;
      out_ch.lane        <= result.lane;
      out_ch.value       <= result.value;
      out_ch.duty_scaled <= result.duty_scaled;
    end
  end

  assign out_ch.valid = out_valid;

endmodule
